// ===== sv/daubechies_wavelet_filter_step_core_macros.svh =====
// Assertion macros for the wavelet filter step core checker.
// Included by sv/dwfs_checker.sv; no other dependencies.
`ifndef DAUBECHIES_WAVELET_FILTER_STEP_CORE_MACROS_SVH
`define DAUBECHIES_WAVELET_FILTER_STEP_CORE_MACROS_SVH

// Check a property while reset is released.
`define DWFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define DWFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/dwfs_pkg.sv =====
// Shared types, constants and coefficient tables for the wavelet filter step.
// Used by every module of the block; depends on nothing.
package dwfs_pkg;

    localparam int ADDR_W   = 6;
    localparam int LEN_W    = 7;
    localparam int STEP_W   = 4;
    localparam int TAP_W    = 5;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int PROD_W   = 33;
    localparam int ACC_W    = 38;
    localparam int RES_W    = 18;

    typedef enum logic [1:0] {
        CFG_TAP_SELECT  = 2'd0,
        CFG_DIRECTION   = 2'd1,
        CFG_LOG2_LENGTH = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        TAPS_4,
        TAPS_12,
        TAPS_20
    } t_taps;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        t_taps             taps;
        logic [STEP_W-1:0] half;
        logic [2:0]        lg;
        logic              dir;
    } t_cfg;

    typedef struct packed {
        logic              wr;
        logic [ADDR_W-1:0] wr_addr;
        logic              issue;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] k;
        logic [STEP_W-1:0] s;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    localparam logic signed [COEF_W-1:0] TAPS4_C [4] = '{
        17'sd31651, 17'sd54822, 17'sd14689, -17'sd8481
    };

    localparam logic signed [COEF_W-1:0] TAPS12_C [12] = '{
        17'sd7310, 17'sd32416, 17'sd49226, 17'sd20660, -17'sd14828, -17'sd8504,
        17'sd6390, 17'sd1804, -17'sd2070, 17'sd36, 17'sd313, -17'sd71
    };

    localparam logic signed [COEF_W-1:0] TAPS20_C [20] = '{
        17'sd1748, 17'sd12332, 17'sd34551, 17'sd45119, 17'sd18427,
        -17'sd16374, -17'sd12842, 17'sd8347, 17'sd6099, -17'sd4679,
        -17'sd1931, 17'sd2177, 17'sd236, -17'sd703, 17'sd91,
        17'sd131, -17'sd45, -17'sd8, 17'sd6, -17'sd1
    };

    // Smooth tap t of the selected filter, Q1.16.
    function automatic logic signed [COEF_W-1:0] tap_coef(t_taps taps, logic [TAP_W-1:0] t);
        logic signed [COEF_W-1:0] r;
        r = '0;
        unique case (taps)
            TAPS_4: begin
                r = TAPS4_C[t[1:0]];
            end
            TAPS_12: begin
                r = (t < TAP_W'(12)) ? TAPS12_C[t[3:0]] : TAPS12_C[0];
            end
            TAPS_20: begin
                r = (t < TAP_W'(20)) ? TAPS20_C[t] : TAPS20_C[0];
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== sv/daubechies_wavelet_filter_step_core.sv =====
// Top level of the periodic Daubechies wavelet filter step.
// Depends on dwfs_pkg, dwfs_ctrl and dwfs_dp.
//
// Usage:
//   Configuration channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data)
//   writes tap_select (0), direction (1) and log2_length (2); o_cfg_ready is
//   always high. Write only while the core is loading with no partial vector.
//   Input channel (i_in_valid/o_in_ready, i_sample) takes 2^L samples, one
//   transaction per cycle, in index order. The transaction that completes the
//   vector starts the transform; input stalls until the last result is taken.
//   Output channel (o_out_valid/i_out_ready, o_coefficient, o_last_out) gives
//   2^L results in index order; o_last_out marks the final one.
//   Each result is built by the dual multiply-accumulate (one sample memory
//   read pair and two products per cycle), then passes through the product,
//   accumulate and round/saturate registers before it is offered.
//   A receiver stall holds the current result; computation of the next one
//   starts on the cycle after the transaction completes.
//   Reset: registers return to twelve taps, forward, length 64, the load
//   count clears, and no result is pending. The sample memory is not cleared.
module daubechies_wavelet_filter_step_core #(
    parameter int MAX_LENGTH = 64,
    parameter int MAX_TAPS   = 20
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [2:0]                           i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [dwfs_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [dwfs_pkg::RES_W-1:0]    o_coefficient,
    output logic                                 o_last_out
);

    // largest log2 length that fits the sample memory
    localparam int LMAX_RAW = $clog2(MAX_LENGTH + 1) - 1;
    localparam int LMAX     = (LMAX_RAW > 6) ? 6 : ((LMAX_RAW < 2) ? 2 : LMAX_RAW);

    logic [1:0] r_tap_select;
    logic       r_direction;
    logic [2:0] r_log2_length;

    // register writes; index 3 is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_select  <= 2'd1;
            r_direction   <= 1'b0;
            r_log2_length <= 3'd6;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dwfs_pkg::CFG_TAP_SELECT:  r_tap_select  <= i_cfg_data[1:0];
                dwfs_pkg::CFG_DIRECTION:   r_direction   <= i_cfg_data[0];
                dwfs_pkg::CFG_LOG2_LENGTH: r_log2_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // effective settings: clamp length, map the unused selector to twelve
    // taps, step the tap count down to what MAX_TAPS allows
    dwfs_pkg::t_cfg cfg;
    dwfs_pkg::t_taps taps_req;
    logic [2:0]      lg_clamp;

    always_comb begin
        priority if (r_log2_length < 3'd2) lg_clamp = 3'd2;
        else if (r_log2_length > 3'(LMAX)) lg_clamp = 3'(LMAX);
        else lg_clamp = r_log2_length;

        priority if (r_tap_select == 2'd0) taps_req = dwfs_pkg::TAPS_4;
        else if (r_tap_select == 2'd2) taps_req = dwfs_pkg::TAPS_20;
        else taps_req = dwfs_pkg::TAPS_12;

        cfg.taps = taps_req;
        if (taps_req == dwfs_pkg::TAPS_20 && MAX_TAPS < 20) begin
            cfg.taps = (MAX_TAPS >= 12) ? dwfs_pkg::TAPS_12 : dwfs_pkg::TAPS_4;
        end else if (taps_req == dwfs_pkg::TAPS_12 && MAX_TAPS < 12) begin
            cfg.taps = dwfs_pkg::TAPS_4;
        end

        unique case (cfg.taps)
            dwfs_pkg::TAPS_4:  cfg.half = dwfs_pkg::STEP_W'(2);
            dwfs_pkg::TAPS_20: cfg.half = dwfs_pkg::STEP_W'(10);
            default:           cfg.half = dwfs_pkg::STEP_W'(6);
        endcase
        cfg.lg  = lg_clamp;
        cfg.dir = r_direction;
    end

    dwfs_pkg::t_cmd    cmd;
    dwfs_pkg::t_status status;

    dwfs_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_last_out  (o_last_out),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dwfs_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_sample      (i_sample),
        .o_status      (status),
        .o_coefficient (o_coefficient)
    );

endmodule

// ===== sv/dwfs_ctrl.sv =====
// Sequencer for the wavelet filter step: load, per-element tap loop, output.
// Depends on dwfs_pkg.
module dwfs_ctrl #(
    parameter int MAX_LENGTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dwfs_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_last_out,
    input  dwfs_pkg::t_status i_status,
    output dwfs_pkg::t_cmd    o_cmd
);

    localparam int CW = $clog2(MAX_LENGTH + 1);

    dwfs_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                  r_count;
    logic [dwfs_pkg::ADDR_W-1:0]    r_k;
    logic [dwfs_pkg::STEP_W-1:0]    r_s;

    logic [dwfs_pkg::LEN_W-1:0]     len;
    logic [dwfs_pkg::ADDR_W-1:0]    last_k;
    logic [dwfs_pkg::LEN_W-1:0]     count_inc;
    logic                           accept;
    logic                           full;
    logic                           step_end;
    logic                           elem_last;

    assign len       = dwfs_pkg::LEN_W'(1) << i_cfg.lg;
    assign last_k    = dwfs_pkg::ADDR_W'(len - dwfs_pkg::LEN_W'(1));
    assign count_inc = dwfs_pkg::LEN_W'(r_count) + dwfs_pkg::LEN_W'(1);
    assign accept    = i_in_valid && (r_state == dwfs_pkg::ST_LOAD);
    assign full      = count_inc >= len;
    assign step_end  = r_s == (i_cfg.half - dwfs_pkg::STEP_W'(1));
    assign elem_last = r_k == last_k;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwfs_pkg::ST_LOAD: begin
                if (accept && full) n_state = dwfs_pkg::ST_CALC;
            end
            dwfs_pkg::ST_CALC: begin
                if (step_end) n_state = dwfs_pkg::ST_WAIT;
            end
            dwfs_pkg::ST_WAIT: begin
                if (i_status.done) n_state = dwfs_pkg::ST_OUT;
            end
            dwfs_pkg::ST_OUT: begin
                if (i_out_ready) n_state = elem_last ? dwfs_pkg::ST_LOAD : dwfs_pkg::ST_CALC;
            end
            default: begin
                n_state = dwfs_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = r_state == dwfs_pkg::ST_LOAD;
        o_out_valid   = r_state == dwfs_pkg::ST_OUT;
        o_last_out    = elem_last;
        o_cmd.wr      = accept && (r_count < CW'(MAX_LENGTH));
        o_cmd.wr_addr = dwfs_pkg::ADDR_W'(r_count);
        o_cmd.issue   = r_state == dwfs_pkg::ST_CALC;
        o_cmd.first   = r_s == '0;
        o_cmd.last    = step_end;
        o_cmd.k       = r_k;
        o_cmd.s       = r_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dwfs_pkg::ST_LOAD;
            r_count <= '0;
            r_k     <= '0;
            r_s     <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= full ? '0 : CW'(count_inc);
                if (full) r_k <= '0;
            end
            if (r_state == dwfs_pkg::ST_CALC) begin
                r_s <= step_end ? '0 : r_s + dwfs_pkg::STEP_W'(1);
            end
            if ((r_state == dwfs_pkg::ST_OUT) && i_out_ready) begin
                r_k <= r_k + dwfs_pkg::ADDR_W'(1);
            end
        end
    end

endmodule

// ===== sv/dwfs_dp.sv =====
// Datapath for the wavelet filter step: sample memory, address and tap
// generation, dual multiply-accumulate and round/saturate. Depends on dwfs_pkg.
module dwfs_dp #(
    parameter int MAX_LENGTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dwfs_pkg::t_cfg                       i_cfg,
    input  dwfs_pkg::t_cmd                       i_cmd,
    input  logic signed [dwfs_pkg::SAMPLE_W-1:0] i_sample,
    output dwfs_pkg::t_status                    o_status,
    output logic signed [dwfs_pkg::RES_W-1:0]    o_coefficient
);

    localparam int AW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int AD = dwfs_pkg::ADDR_W;
    localparam int TW = dwfs_pkg::TAP_W;

    logic signed [dwfs_pkg::SAMPLE_W-1:0] mem [MAX_LENGTH];

    // address and tap generation
    logic [dwfs_pkg::LEN_W-1:0] len;
    logic [AD-1:0]              mask, nh, p_fwd, base, tmp, p_tr;
    logic [AD-1:0]              addr_a, addr_b;
    logic [TW-1:0]              ntaps, ta, tb, t_tr;
    logic                       det, par, neg_b;
    logic signed [dwfs_pkg::COEF_W-1:0] ca, cb, cb_raw;

    always_comb begin
        len    = dwfs_pkg::LEN_W'(1) << i_cfg.lg;
        mask   = AD'(len - dwfs_pkg::LEN_W'(1));
        nh     = AD'(len >> 1);
        ntaps  = TW'({i_cfg.half, 1'b0});
        p_fwd  = i_cmd.k & (nh - AD'(1));
        det    = |(i_cmd.k & nh);
        base   = AD'({p_fwd, 1'b0}) + AD'(2) + AD'({i_cmd.s, 1'b0}) - AD'(i_cfg.half);
        par    = i_cmd.k[0] ^ i_cfg.half[0];
        t_tr   = TW'({i_cmd.s, par});
        tmp    = (i_cmd.k + AD'(i_cfg.half) - AD'(2) - AD'(t_tr)) & mask;
        p_tr   = tmp >> 1;
        if (i_cfg.dir) begin
            // transpose: gather the taps of one parity that land on element k
            addr_a = p_tr;
            addr_b = p_tr + nh;
            ta     = t_tr;
            tb     = ntaps - TW'(1) - t_tr;
            neg_b  = t_tr[0];
        end else begin
            addr_a = base & mask;
            addr_b = (base + AD'(1)) & mask;
            if (det) begin
                ta    = ntaps - TW'(1) - TW'({i_cmd.s, 1'b0});
                tb    = ntaps - TW'(2) - TW'({i_cmd.s, 1'b0});
                neg_b = 1'b1;
            end else begin
                ta    = TW'({i_cmd.s, 1'b0});
                tb    = TW'({i_cmd.s, 1'b1});
                neg_b = 1'b0;
            end
        end
        ca     = dwfs_pkg::tap_coef(i_cfg.taps, ta);
        cb_raw = dwfs_pkg::tap_coef(i_cfg.taps, tb);
        cb     = neg_b ? -cb_raw : cb_raw;
    end

    // stage 1: memory read and tap registers
    logic signed [dwfs_pkg::SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic signed [dwfs_pkg::COEF_W-1:0]   r_ca, r_cb;
    logic                                 r_v1, r_first1, r_last1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) mem[i_cmd.wr_addr[AW-1:0]] <= i_sample;
        if (i_cmd.issue) begin
            r_rd_a <= mem[addr_a[AW-1:0]];
            r_rd_b <= mem[addr_b[AW-1:0]];
            r_ca   <= ca;
            r_cb   <= cb;
        end
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last;
    end

    // stage 2: products
    logic signed [dwfs_pkg::PROD_W-1:0] prod_a, prod_b, r_pa, r_pb;
    logic                               r_v2, r_first2, r_last2;

    assign prod_a = r_rd_a * r_ca;
    assign prod_b = r_rd_b * r_cb;

    always_ff @(posedge i_clk) begin
        r_pa     <= prod_a;
        r_pb     <= prod_b;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
    end

    // stage 3: accumulate
    logic signed [dwfs_pkg::ACC_W-1:0] acc_base, pa_x, pb_x, acc_sum, r_acc;
    logic                              r_done3, r_done4;

    assign acc_base = r_first2 ? '0 : r_acc;
    assign pa_x     = dwfs_pkg::ACC_W'(r_pa);
    assign pb_x     = dwfs_pkg::ACC_W'(r_pb);
    assign acc_sum  = acc_base + pa_x + pb_x;

    always_ff @(posedge i_clk) begin
        if (r_v2) r_acc <= acc_sum;
    end

    // stage 4: round half up and saturate
    function automatic logic signed [dwfs_pkg::RES_W-1:0] round_sat(
        logic signed [dwfs_pkg::ACC_W-1:0] a
    );
        logic signed [dwfs_pkg::ACC_W:0]      q;
        logic signed [dwfs_pkg::ACC_W-16:0]   r;
        q = a + $signed((dwfs_pkg::ACC_W + 1)'(32768));
        r = q[dwfs_pkg::ACC_W:16];
        if (r > $signed((dwfs_pkg::ACC_W - 15)'(131071))) begin
            return dwfs_pkg::RES_W'(131071);
        end else if (r < -$signed((dwfs_pkg::ACC_W - 15)'(131072))) begin
            return dwfs_pkg::RES_W'(-131072);
        end
        return dwfs_pkg::RES_W'(r);
    endfunction

    always_ff @(posedge i_clk) begin
        if (r_done3) o_coefficient <= round_sat(r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_done3 <= 1'b0;
            r_done4 <= 1'b0;
        end else begin
            r_v1    <= i_cmd.issue;
            r_v2    <= r_v1;
            r_done3 <= r_v2 && r_last2;
            r_done4 <= r_done3;
        end
    end

    assign o_status.done = r_done4;

endmodule

// ===== sv/dwfs_checker.sv =====
// Port-level checker for the wavelet filter step core, bound to the top.
// Depends on dwfs_pkg and daubechies_wavelet_filter_step_core_macros.svh.
`include "daubechies_wavelet_filter_step_core_macros.svh"

module dwfs_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_cfg_valid,
    input logic                                 o_cfg_ready,
    input logic [1:0]                           i_cfg_index,
    input logic [2:0]                           i_cfg_data,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic signed [dwfs_pkg::SAMPLE_W-1:0] i_sample,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic signed [dwfs_pkg::RES_W-1:0]    o_coefficient,
    input logic                                 o_last_out
);

    `DWFS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result pending after reset")
    `DWFS_ASSERT(a_load_or_emit, !(o_in_ready && o_out_valid), "loading while emitting")
    `DWFS_ASSERT(a_hold_stall, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_coefficient) && $stable(o_last_out), "stalled result changed")
    `DWFS_ASSERT(a_last_ends, o_out_valid && i_out_ready && o_last_out |=> o_in_ready && !o_out_valid, "no return to load after last")

endmodule

bind daubechies_wavelet_filter_step_core dwfs_checker u_dwfs_checker (.*);
